@@ sv/tsaq_pkg.sv @@
package tsaq_pkg;

    localparam int QUEUE_DEPTH = 128;
    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int AVG_COUNT = 3;
    localparam int COUNT_W = 2;
    localparam logic [COUNT_W-1:0] COUNT_LAST = COUNT_W'(AVG_COUNT - 1);

    localparam int AVG_SHIFT = 17;
    localparam int AVG_RECIP = (2 ** AVG_SHIFT + AVG_COUNT - 1) / AVG_COUNT;
    localparam int AVG_PROD_W = 34;

    localparam int RAW_W = 12;
    localparam int COORD_W = 16;
    localparam int STAMP_W = 16;
    localparam int PRESS_W = 10;
    localparam logic signed [COORD_W-1:0] RAW_OFFSET = 16'sd4000;
    localparam logic [PRESS_W-1:0] PRESSURE_DOWN = 10'd1000;
    localparam logic [PRESS_W-1:0] PRESSURE_UP = 10'd0;

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_READ = 1'b1;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 12;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_X = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_Y = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_X = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_Y = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCREEN_WIDTH = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCREEN_HEIGHT = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_CAL_ENABLE = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_AXIS_REVERSE = 3'd7;

    localparam int PROD_W = 31;
    localparam int SPAN_W = 13;
    localparam int DIV_DVD_W = 28;
    localparam int DIV_DSR_W = 12;
    localparam int DIV_Q_W = 16;
    localparam int DIV_STEPS = DIV_DVD_W / 2;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef struct packed {
        logic                req_type;
        logic                pen_down;
        logic [RAW_W-1:0]    raw_x;
        logic [RAW_W-1:0]    raw_y;
        logic [STAMP_W-1:0]  tick_stamp;
    } in_word_t;

    typedef struct packed {
        logic                       event_valid;
        logic [PRESS_W-1:0]         pressure;
        logic signed [COORD_W-1:0]  pos_x;
        logic signed [COORD_W-1:0]  pos_y;
        logic [STAMP_W-1:0]         stamp;
    } out_word_t;

    typedef struct packed {
        logic                       pen;
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
        logic [STAMP_W-1:0]         stamp;
    } ring_entry_t;

    typedef struct packed {
        logic                  start;
        logic [DIV_DVD_W-1:0]  dividend;
        logic [DIV_DSR_W-1:0]  divisor;
    } div_req_t;

    function automatic logic signed [COORD_W-1:0] div_by_avg(input logic signed [COORD_W-1:0] a);
        logic [COORD_W-1:0]    mag;
        logic [AVG_PROD_W-1:0] prod;
        logic [COORD_W-1:0]    q;
        mag = a[COORD_W-1] ? COORD_W'(-a) : COORD_W'(a);
        prod = AVG_PROD_W'(mag) * AVG_PROD_W'(AVG_RECIP);
        q = COORD_W'(prod >> AVG_SHIFT);
        return a[COORD_W-1] ? $signed(-q) : $signed(q);
    endfunction

endpackage

@@ sv/touch_sample_average_queue_calibrate_unit.sv @@
// Touch samples and read requests share one input channel. A sample that queues an event
// into the 128-entry event memory passes through a push state before the next word is
// accepted. A read of an empty queue goes straight to the done state; an uncalibrated read
// first fetches the entry. A calibrated read also passes through the multiply and divide
// states, where the two radix-4 dividers (two quotient bits per cycle, fourteen steps) scale
// both axes at once. One word is handled at a time; a finished result waits in the output
// register while the next word is accepted. The event memory needs no clearing after reset.
module touch_sample_average_queue_calibrate_unit import tsaq_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  in_word_t                in_word,
    output logic                    out_valid,
    input  logic                    out_ready,
    output out_word_t               out_word,
    input  logic                    cfg_we,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PUSH = 3'd1;
    localparam logic [2:0] ST_FETCH = 3'd2;
    localparam logic [2:0] ST_MUL = 3'd3;
    localparam logic [2:0] ST_DIV = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [RAW_W-1:0] max_x_reg, max_y_reg, min_x_reg, min_y_reg;
    logic [RAW_W-1:0] screen_width_reg, screen_height_reg;
    logic             cal_enable_reg;
    logic [1:0]       axis_reverse_reg;

    logic [2:0]                 state_reg, state_next;
    logic signed [COORD_W-1:0]  sum_x_reg, sum_x_next, sum_y_reg, sum_y_next;
    logic [COUNT_W-1:0]         count_reg, count_next;
    logic                       pen_was_down_reg, pen_was_down_next;
    logic [PTR_W-1:0]           wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic                       out_valid_reg, out_valid_next;

    ring_entry_t                pend_reg, pend_next;
    logic                       pend_avg_reg, pend_avg_next;
    ring_entry_t                entry_reg, entry_next;
    logic signed [PROD_W-1:0]   prod_x_reg, prod_x_next, prod_y_reg, prod_y_next;
    logic signed [SPAN_W-1:0]   span_x_reg, span_x_next, span_y_reg, span_y_next;
    out_word_t                  res_reg, res_next;
    out_word_t                  out_word_reg, out_word_next;

    logic                       ram_we, ram_re;
    ring_entry_t                ram_wdata, ram_rdata;

    div_req_t                   div_req_x, div_req_y;
    logic                       div_done_x, div_done_y;
    logic [DIV_Q_W-1:0]         quo_x, quo_y;

    logic                       in_fire;
    logic signed [COORD_W-1:0]  samp_x, samp_y, sum_x_add, sum_y_add;
    logic [PTR_W-1:0]           wr_ptr_inc, rd_ptr_inc;
    logic signed [PROD_W-1:0]   prod_x_mag, prod_y_mag;
    logic signed [SPAN_W-1:0]   span_x_mag, span_y_mag;
    logic signed [COORD_W-1:0]  pos_x_cal, pos_y_cal;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
    endfunction

    function automatic logic signed [PROD_W-1:0] axis_product(
        input logic signed [COORD_W-1:0] v,
        input logic [RAW_W-1:0]          hi,
        input logic [RAW_W-1:0]          lo,
        input logic [RAW_W-1:0]          res,
        input logic                      rev
    );
        logic signed [COORD_W+1:0] num;
        logic signed [RAW_W:0]     res_s;
        num = rev ? ($signed({6'b0, hi}) - (COORD_W+2)'(v))
                  : ((COORD_W+2)'(v) - $signed({6'b0, lo}));
        res_s = $signed({1'b0, res});
        return PROD_W'(num) * PROD_W'(res_s);
    endfunction

    function automatic logic signed [SPAN_W-1:0] axis_span(
        input logic [RAW_W-1:0] hi,
        input logic [RAW_W-1:0] lo
    );
        return $signed({1'b0, hi}) - $signed({1'b0, lo});
    endfunction

    function automatic logic signed [COORD_W-1:0] axis_result(
        input logic signed [PROD_W-1:0] prod,
        input logic signed [SPAN_W-1:0] span,
        input logic [DIV_Q_W-1:0]       quo
    );
        logic neg;
        neg = prod[PROD_W-1] ^ span[SPAN_W-1];
        if (span == '0)
        begin
            return '0;
        end
        return neg ? $signed(-quo) : $signed(quo);
    endfunction

    tsaq_ram #(
        .WIDTH ($bits(ring_entry_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_ptr_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    tsaq_divider u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req_x),
        .done     (div_done_x),
        .quotient (quo_x)
    );

    tsaq_divider u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req_y),
        .done     (div_done_y),
        .quotient (quo_y)
    );

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_word = out_word_reg;

    assign samp_x = RAW_OFFSET - $signed({4'b0, in_word.raw_x});
    assign samp_y = RAW_OFFSET - $signed({4'b0, in_word.raw_y});
    assign sum_x_add = sum_x_reg + samp_x;
    assign sum_y_add = sum_y_reg + samp_y;
    assign wr_ptr_inc = ptr_inc(wr_ptr_reg);
    assign rd_ptr_inc = ptr_inc(rd_ptr_reg);

    assign prod_x_mag = prod_x_reg[PROD_W-1] ? -prod_x_reg : prod_x_reg;
    assign prod_y_mag = prod_y_reg[PROD_W-1] ? -prod_y_reg : prod_y_reg;
    assign span_x_mag = span_x_reg[SPAN_W-1] ? -span_x_reg : span_x_reg;
    assign span_y_mag = span_y_reg[SPAN_W-1] ? -span_y_reg : span_y_reg;
    assign pos_x_cal = axis_result(prod_x_reg, span_x_reg, quo_x);
    assign pos_y_cal = axis_result(prod_y_reg, span_y_reg, quo_y);

    always_comb
    begin
        state_next = state_reg;
        sum_x_next = sum_x_reg;
        sum_y_next = sum_y_reg;
        count_next = count_reg;
        pen_was_down_next = pen_was_down_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        out_valid_next = out_valid_reg && !out_ready;
        pend_next = pend_reg;
        pend_avg_next = pend_avg_reg;
        entry_next = entry_reg;
        prod_x_next = prod_x_reg;
        prod_y_next = prod_y_reg;
        span_x_next = span_x_reg;
        span_y_next = span_y_reg;
        res_next = res_reg;
        out_word_next = out_word_reg;
        ram_we = 1'b0;
        ram_re = 1'b0;
        ram_wdata = pend_reg;
        div_req_x = '0;
        div_req_y = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_word.req_type == REQ_READ)
                    begin
                        if (wr_ptr_reg == rd_ptr_reg)
                        begin
                            res_next = '0;
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            ram_re = 1'b1;
                            rd_ptr_next = rd_ptr_inc;
                            state_next = ST_FETCH;
                        end
                    end
                    else if (in_word.pen_down)
                    begin
                        pen_was_down_next = 1'b1;
                        if (count_reg == COUNT_LAST)
                        begin
                            pend_next = '{pen: 1'b1, x: sum_x_add, y: sum_y_add,
                                          stamp: in_word.tick_stamp};
                            pend_avg_next = 1'b1;
                            sum_x_next = '0;
                            sum_y_next = '0;
                            count_next = '0;
                            state_next = ST_PUSH;
                        end
                        else
                        begin
                            sum_x_next = sum_x_add;
                            sum_y_next = sum_y_add;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    else if (pen_was_down_reg)
                    begin
                        pen_was_down_next = 1'b0;
                        pend_next = '{pen: 1'b0, x: samp_x, y: samp_y,
                                      stamp: in_word.tick_stamp};
                        pend_avg_next = 1'b0;
                        sum_x_next = '0;
                        sum_y_next = '0;
                        count_next = '0;
                        state_next = ST_PUSH;
                    end
                end
            end
            ST_PUSH:
            begin
                ram_we = 1'b1;
                if (pend_avg_reg)
                begin
                    ram_wdata.x = div_by_avg(pend_reg.x);
                    ram_wdata.y = div_by_avg(pend_reg.y);
                end
                wr_ptr_next = wr_ptr_inc;
                if (wr_ptr_inc == rd_ptr_reg)
                begin
                    rd_ptr_next = rd_ptr_inc;
                end
                state_next = ST_IDLE;
            end
            ST_FETCH:
            begin
                entry_next = ram_rdata;
                if (cal_enable_reg)
                begin
                    prod_x_next = axis_product(ram_rdata.x, max_x_reg, min_x_reg,
                                               screen_width_reg, axis_reverse_reg[0]);
                    prod_y_next = axis_product(ram_rdata.y, max_y_reg, min_y_reg,
                                               screen_height_reg, axis_reverse_reg[1]);
                    span_x_next = axis_span(max_x_reg, min_x_reg);
                    span_y_next = axis_span(max_y_reg, min_y_reg);
                    state_next = ST_MUL;
                end
                else
                begin
                    res_next.event_valid = 1'b1;
                    res_next.pressure = ram_rdata.pen ? PRESSURE_DOWN : PRESSURE_UP;
                    res_next.pos_x = ram_rdata.x;
                    res_next.pos_y = ram_rdata.y;
                    res_next.stamp = ram_rdata.stamp;
                    state_next = ST_DONE;
                end
            end
            ST_MUL:
            begin
                div_req_x = '{start: 1'b1, dividend: prod_x_mag[DIV_DVD_W-1:0],
                              divisor: span_x_mag[DIV_DSR_W-1:0]};
                div_req_y = '{start: 1'b1, dividend: prod_y_mag[DIV_DVD_W-1:0],
                              divisor: span_y_mag[DIV_DSR_W-1:0]};
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done_x)
                begin
                    res_next.event_valid = 1'b1;
                    res_next.pressure = entry_reg.pen ? PRESSURE_DOWN : PRESSURE_UP;
                    res_next.pos_x = pos_x_cal;
                    res_next.pos_y = pos_y_cal;
                    res_next.stamp = entry_reg.stamp;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_word_next = res_reg;
                    out_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_x_reg <= 12'd4000;
            max_y_reg <= 12'd4000;
            min_x_reg <= 12'd200;
            min_y_reg <= 12'd200;
            screen_width_reg <= 12'd240;
            screen_height_reg <= 12'd320;
            cal_enable_reg <= 1'b0;
            axis_reverse_reg <= 2'b00;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MAX_X:         max_x_reg <= cfg_data;
                CFG_MAX_Y:         max_y_reg <= cfg_data;
                CFG_MIN_X:         min_x_reg <= cfg_data;
                CFG_MIN_Y:         min_y_reg <= cfg_data;
                CFG_SCREEN_WIDTH:  screen_width_reg <= cfg_data;
                CFG_SCREEN_HEIGHT: screen_height_reg <= cfg_data;
                CFG_CAL_ENABLE:    cal_enable_reg <= cfg_data[0];
                CFG_AXIS_REVERSE:  axis_reverse_reg <= cfg_data[1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sum_x_reg <= '0;
            sum_y_reg <= '0;
            count_reg <= '0;
            pen_was_down_reg <= 1'b0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sum_x_reg <= sum_x_next;
            sum_y_reg <= sum_y_next;
            count_reg <= count_next;
            pen_was_down_reg <= pen_was_down_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        pend_avg_reg <= pend_avg_next;
        entry_reg <= entry_next;
        prod_x_reg <= prod_x_next;
        prod_y_reg <= prod_y_next;
        span_x_reg <= span_x_next;
        span_y_reg <= span_y_next;
        res_reg <= res_next;
        out_word_reg <= out_word_next;
    end

`ifndef SYNTHESIS
    // A push that meets the read position must advance it, so the ring never looks empty.
    a_push_keeps_entry: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PUSH |=> wr_ptr_reg != rd_ptr_reg)
        else $error("event push left the ring looking empty");

    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        div_done_x == div_done_y)
        else $error("axis dividers out of step");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_LAST)
        else $error("sample count beyond the averaging window");

    a_empty_read: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_word.req_type == REQ_READ && wr_ptr_reg == rd_ptr_reg)
        |=> (state_reg == ST_DONE && !res_reg.event_valid))
        else $error("read of an empty queue returned an event");
`endif

endmodule

@@ sv/tsaq_ram.sv @@
module tsaq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [$clog2(DEPTH)-1:0]  waddr,
    input  logic [WIDTH-1:0]          wdata,
    input  logic                      re,
    input  logic [$clog2(DEPTH)-1:0]  raddr,
    output logic [WIDTH-1:0]          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ sv/tsaq_divider.sv @@
module tsaq_divider import tsaq_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  div_req_t            req,
    output logic                done,
    output logic [DIV_Q_W-1:0]  quotient
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_CNT_W-1:0]  count_reg, count_next;
    logic [DIV_DVD_W-1:0]  dvd_reg, dvd_next;
    logic [DIV_DSR_W-1:0]  dsr_reg, dsr_next;
    logic [DIV_DSR_W-1:0]  rem_reg, rem_next;
    logic [DIV_Q_W-1:0]    quo_reg, quo_next;

    logic [DIV_DSR_W:0]    trial1, trial2;
    logic [DIV_DSR_W-1:0]  rem1, rem2;
    logic                  ge1, ge2;

    always_comb
    begin
        trial1 = {rem_reg, dvd_reg[DIV_DVD_W-1]};
        ge1 = trial1 >= {1'b0, dsr_reg};
        rem1 = ge1 ? DIV_DSR_W'(trial1 - {1'b0, dsr_reg}) : DIV_DSR_W'(trial1);
        trial2 = {rem1, dvd_reg[DIV_DVD_W-2]};
        ge2 = trial2 >= {1'b0, dsr_reg};
        rem2 = ge2 ? DIV_DSR_W'(trial2 - {1'b0, dsr_reg}) : DIV_DSR_W'(trial2);

        busy_next = busy_reg;
        done_next = 1'b0;
        count_next = count_reg;
        dvd_next = dvd_reg;
        dsr_next = dsr_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;

        if (req.start)
        begin
            busy_next = 1'b1;
            count_next = DIV_CNT_W'(DIV_STEPS - 1);
            dvd_next = req.dividend;
            dsr_next = req.divisor;
            rem_next = '0;
            quo_next = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[DIV_DVD_W-3:0], 2'b00};
            rem_next = rem2;
            quo_next = {quo_reg[DIV_Q_W-3:0], ge1, ge2};
            count_next = count_reg - 1'b1;
            if (count_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quotient = quo_reg;

endmodule
